>>> rtl/arv_pkg.sv
package arv_pkg;

    localparam logic [31:0] REC_MAGIC = 32'h4841_4c31;
    localparam logic [31:0] CRC_POLY  = 32'hedb8_8320;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [10:0] REC_LEN   = 11'd1232;
    localparam logic [10:0] HEAD_LEN  = 11'd52;
    localparam logic [10:0] ENTRY_END = 11'd1228;
    localparam logic [10:0] POS_MAX   = 11'd2047;
    localparam logic [7:0]  SLOT_LAST = 8'd195;
    localparam logic [7:0]  DEV_FIRST = 8'd4;
    localparam logic [7:0]  CAP_FIRST = 8'd132;
    localparam logic [7:0]  DEV_CAP   = 8'd128;
    localparam logic [7:0]  CAPA_CAP  = 8'd64;
    localparam logic [7:0]  MIN_PRINT = 8'h20;
    localparam logic [7:0]  BIND_LIMIT = 8'd6;
    localparam logic [2:0]  SLOT_COUNT_M1 = 3'd5;
    localparam int          TEXT_SLOT = 192;
    localparam int          ADDR_W    = 8;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_LENGTH   = 4'd1;
    localparam logic [3:0] ST_MAGIC    = 4'd2;
    localparam logic [3:0] ST_VERSION  = 4'd3;
    localparam logic [3:0] ST_SIZE     = 4'd4;
    localparam logic [3:0] ST_CRC      = 4'd5;
    localparam logic [3:0] ST_RESERVED = 4'd6;
    localparam logic [3:0] ST_ZERO_GEN = 4'd7;
    localparam logic [3:0] ST_COUNT    = 4'd8;
    localparam logic [3:0] ST_INDEX    = 4'd9;
    localparam logic [3:0] ST_REUSED   = 4'd10;
    localparam logic [3:0] ST_DEVICE   = 4'd11;
    localparam logic [3:0] ST_CAPA     = 4'd12;
    localparam logic [3:0] ST_DUP      = 4'd13;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] generation;
        logic [7:0]  stored_count;
    } t_out;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [10:0] pos;
        logic [2:0]  idx;
        logic [7:0]  off;
        logic        in_slot;
    } t_item;

    typedef struct packed {
        logic [1:0] count;
    } t_bstat;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> rtl/arv_ram.sv
module arv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/arv_front.sv
module arv_front import arv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in               i_data,
    input  logic              i_hold,
    output logic              o_item_v,
    output t_item             o_item,
    output logic [ADDR_W-1:0] o_raddr
);
    logic [10:0] r_pos;
    logic [2:0]  r_idx;
    logic [7:0]  r_off;
    logic        r_item_v;
    t_item       r_item;
    logic        w_take;
    logic        w_in_slot;

    assign w_take    = i_valid && !i_hold;
    assign w_in_slot = (r_pos >= HEAD_LEN) && (r_pos < ENTRY_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_idx    <= '0;
            r_off    <= '0;
            r_item_v <= 1'b0;
        end else begin
            r_item_v <= w_take;
            if (w_take) begin
                if (i_data.last_byte) begin
                    r_pos <= '0;
                    r_idx <= '0;
                    r_off <= '0;
                end else begin
                    if (r_pos != POS_MAX) begin
                        r_pos <= r_pos + 11'd1;
                    end
                    if (w_in_slot) begin
                        if (r_off == SLOT_LAST) begin
                            r_off <= '0;
                            if (r_idx != SLOT_COUNT_M1) begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end else begin
                            r_off <= r_off + 8'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte <= i_data.data_byte;
            r_item.last_byte <= i_data.last_byte;
            r_item.pos       <= r_pos;
            r_item.idx       <= r_idx;
            r_item.off       <= r_off;
            r_item.in_slot   <= w_in_slot;
        end
    end

    // text offset is the slot offset less the index and padding bytes
    assign o_raddr  = (r_off >= DEV_FIRST) ? (r_off - DEV_FIRST) : '0;
    assign o_item_v = r_item_v;
    assign o_item   = r_item;
endmodule

>>> rtl/arv_back.sv
module arv_back import arv_pkg::*; #(
    parameter int MAX_ENTRIES = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_item_v,
    input  t_item             i_item,
    input  logic [ADDR_W-1:0] i_raddr,
    input  logic              i_stall,
    output logic              o_valid,
    output t_out              o_data,
    output logic              o_hold,
    output t_bstat            o_stat
);
    logic [15:0] r_schema;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_hs, n_hs;
    logic [31:0] r_scrc, n_scrc;
    logic [31:0] r_gen, n_gen;
    logic [7:0]  r_cnt, n_cnt;
    logic [5:0]  r_used, n_used;
    logic [MAX_ENTRIES-1:0] r_peq, n_peq;
    logic [1:0]  r_ended, n_ended;
    logic [3:0]  r_herr, n_herr;
    logic        r_rerr, n_rerr;
    logic [3:0]  r_recerr, n_recerr;

    logic [7:0] w_rd [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_out w_res;

    t_out       r_q [2];
    logic       r_head;
    logic [1:0] r_qcnt;
    logic       w_push, w_pop;

    assign w_waddr = i_item.off - DEV_FIRST;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_bank
        arv_ram #(.WIDTH(8), .DEPTH(TEXT_SLOT)) u_bank (
            .i_clk  (i_clk),
            .i_we   (w_we[g]),
            .i_waddr(w_waddr),
            .i_wdata(i_item.data_byte),
            .i_raddr(i_raddr),
            .o_rdata(w_rd[g])
        );
    end

    always_comb begin
        logic [7:0]  b;
        logic [10:0] p;
        logic        active;
        logic        which;
        logic [7:0]  k;
        logic [7:0]  cap;
        logic [3:0]  code;
        logic        is_text;
        logic [MAX_ENTRIES-1:0] mask;
        logic [3:0]  st;

        b = i_item.data_byte;
        p = i_item.pos;
        n_crc = r_crc; n_hs = r_hs; n_scrc = r_scrc; n_gen = r_gen; n_cnt = r_cnt;
        n_used = r_used; n_peq = r_peq; n_ended = r_ended; n_herr = r_herr;
        n_rerr = r_rerr; n_recerr = r_recerr;
        w_we = '0;
        active = 1'b0; which = 1'b0; k = '0; cap = DEV_CAP; code = ST_DEVICE;
        is_text = 1'b0; mask = '0; st = ST_OK;

        if (i_item_v && p < REC_LEN) begin
            n_crc = crc_byte(r_crc, (p >= 11'd12 && p <= 11'd15) ? 8'd0 : b);
            n_hs  = {b, r_hs[31:8]};
            if (p == 11'd3) begin
                if (n_hs != REC_MAGIC && r_herr == ST_OK) n_herr = ST_MAGIC;
            end else if (p == 11'd5) begin
                if (n_hs[31:16] != r_schema && r_herr == ST_OK) n_herr = ST_VERSION;
            end else if (p == 11'd7) begin
                if (n_hs[31:16] != {5'd0, REC_LEN} && r_herr == ST_OK) n_herr = ST_SIZE;
            end else if (p == 11'd11) begin
                n_gen = n_hs;
            end else if (p == 11'd15) begin
                n_scrc = n_hs;
            end else if (p == 11'd48) begin
                n_cnt = b;
                if (r_recerr == ST_OK) begin
                    if (r_gen == '0) n_recerr = ST_ZERO_GEN;
                    else if (b > 8'(MAX_ENTRIES)) n_recerr = ST_COUNT;
                end
            end else if (p >= 11'd49 && p <= 11'd51 && b != 8'd0) begin
                n_rerr = 1'b1;
            end

            if (i_item.in_slot && 32'(i_item.idx) < MAX_ENTRIES) begin
                active = {5'd0, i_item.idx} < r_cnt;
                if (i_item.off == 8'd0) begin
                    n_peq = '1;
                    n_ended = '0;
                    if (active) begin
                        if (b >= BIND_LIMIT) begin
                            if (n_recerr == ST_OK) n_recerr = ST_INDEX;
                        end else if (r_used[b[2:0]]) begin
                            if (n_recerr == ST_OK) n_recerr = ST_REUSED;
                        end else begin
                            n_used[b[2:0]] = 1'b1;
                        end
                    end
                end else if (i_item.off >= DEV_FIRST && i_item.off < CAP_FIRST) begin
                    is_text = 1'b1; which = 1'b0; k = i_item.off - DEV_FIRST;
                    cap = DEV_CAP; code = ST_DEVICE;
                end else if (i_item.off >= CAP_FIRST) begin
                    is_text = 1'b1; which = 1'b1; k = i_item.off - CAP_FIRST;
                    cap = CAPA_CAP; code = ST_CAPA;
                end

                if (is_text && !r_ended[which]) begin
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (j < 32'(i_item.idx) && w_rd[j] != b) n_peq[j] = 1'b0;
                    end
                    w_we[i_item.idx[$clog2(MAX_ENTRIES+1)-1:0]] = 1'b1;
                    if (b == 8'd0) begin
                        if (k == 8'd0 && active && n_recerr == ST_OK) n_recerr = code;
                        n_ended[which] = 1'b1;
                    end else if (active && (b < MIN_PRINT || k == cap - 8'd1)) begin
                        if (n_recerr == ST_OK) n_recerr = code;
                    end
                end

                for (int j = 0; j < MAX_ENTRIES; j++) begin
                    mask[j] = j < 32'(i_item.idx);
                end
                if (i_item.off == SLOT_LAST && active && (n_peq & mask) != '0) begin
                    if (n_recerr == ST_OK) n_recerr = ST_DUP;
                end
            end
        end

        if (p != REC_LEN - 11'd1) st = ST_LENGTH;
        else if (n_herr != ST_OK) st = n_herr;
        else if ((n_crc ^ ALL_ONES) != n_scrc) st = ST_CRC;
        else if (n_rerr) st = ST_RESERVED;
        else st = n_recerr;

        w_res.status = st;
        if (st >= ST_LENGTH && st <= ST_RESERVED) begin
            w_res.generation   = '0;
            w_res.stored_count = '0;
        end else begin
            w_res.generation   = n_gen;
            w_res.stored_count = n_cnt;
        end
    end

    assign w_push = i_item_v && i_item.last_byte;
    assign w_pop  = (r_qcnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_schema <= 16'd1;
            r_crc    <= ALL_ONES;
            r_hs     <= '0;
            r_scrc   <= '0;
            r_gen    <= '0;
            r_cnt    <= '0;
            r_used   <= '0;
            r_peq    <= '1;
            r_ended  <= '0;
            r_herr   <= ST_OK;
            r_rerr   <= 1'b0;
            r_recerr <= ST_OK;
            r_head   <= 1'b0;
            r_qcnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_schema <= i_cfg_data;
            end
            if (i_item_v) begin
                if (i_item.last_byte) begin
                    r_crc    <= ALL_ONES;
                    r_hs     <= '0;
                    r_scrc   <= '0;
                    r_gen    <= '0;
                    r_cnt    <= '0;
                    r_used   <= '0;
                    r_peq    <= '1;
                    r_ended  <= '0;
                    r_herr   <= ST_OK;
                    r_rerr   <= 1'b0;
                    r_recerr <= ST_OK;
                end else begin
                    r_crc    <= n_crc;
                    r_hs     <= n_hs;
                    r_scrc   <= n_scrc;
                    r_gen    <= n_gen;
                    r_cnt    <= n_cnt;
                    r_used   <= n_used;
                    r_peq    <= n_peq;
                    r_ended  <= n_ended;
                    r_herr   <= n_herr;
                    r_rerr   <= n_rerr;
                    r_recerr <= n_recerr;
                end
            end
            if (w_pop) begin
                r_head <= !r_head;
            end
            r_qcnt <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // result queue write slot is the head when the queue is empty, else the slot behind it
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_head ^ (r_qcnt != 2'd0)] <= w_res;
        end
    end

    assign o_valid      = r_qcnt != 2'd0;
    assign o_data       = r_q[r_head];
    assign o_hold       = ({1'b0, r_qcnt} + {2'b0, w_push}) >= (3'd2 + {2'b0, w_pop});
    assign o_stat.count = r_qcnt;
endmodule

>>> rtl/alias_record_validator_core.sv
// Record validator: takes one record byte per transfer and returns one status
// transfer for each byte marked last. While o_stall is low, one byte per clock
// is sustained: the front stage tracks the byte position and issues reads of
// the six banked entry-text RAMs, and the back stage folds the CRC and compares
// against the earlier entries in the next cycle. A result sits in a two-entry
// queue; o_stall rises only while that queue could not take another result.
module alias_record_validator_core import arv_pkg::*; #(
    parameter int MAX_ENTRIES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_out        o_data,
    input  logic        i_stall
);
    logic              w_item_v;
    t_item             w_item;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_hold;
    t_bstat            w_stat;

    arv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_hold  (w_hold),
        .o_item_v(w_item_v),
        .o_item  (w_item),
        .o_raddr (w_raddr)
    );

    arv_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_item_v  (w_item_v),
        .i_item    (w_item),
        .i_raddr   (w_raddr),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_hold    (w_hold),
        .o_stat    (w_stat)
    );

    assign o_stall = w_hold;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= 2'd2) else $error("result queue overflow");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.count == 2'd2 && i_stall) |-> o_stall) else $error("input open with full queue");
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_v && w_item.last_byte && !o_valid) |=> o_valid)
        else $error("result lost");
`endif
endmodule

>>> dv/alias_record_validator_core_test.sv
`timescale 1ns / 1ps

module alias_record_validator_core_test;
    import arv_pkg::*;

    localparam int REC_BYTES = 1232;
    localparam int SLOT_BYTES = 196;
    localparam int TEXT_BYTES = 192;
    localparam int NUM_SLOTS = 6;
    localparam int CYCLE_LIMIT = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    t_in         i_data;
    logic        o_stall;
    logic        o_valid;
    t_out        o_data;
    logic        i_stall;

    alias_record_validator_core #(.MAX_ENTRIES(NUM_SLOTS)) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .i_data(i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data(o_data),
        .i_stall(i_stall)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // validator state as predicted
    logic [15:0] schema_q;
    logic [10:0] pos_q;
    logic [31:0] crc_q;
    logic [31:0] shift_q;
    logic [31:0] stored_crc_q;
    logic [31:0] gen_q;
    logic [7:0]  count_q;
    logic [5:0]  used_q;
    logic [7:0]  text_store [0:NUM_SLOTS*TEXT_BYTES-1];
    logic [5:0]  same_pair_q;
    logic [1:0]  text_done_q;
    logic [3:0]  head_err_q;
    logic        resv_err_q;
    logic [3:0]  rec_err_q;

    t_out        status_q [$];
    int          failures = 0;
    int          cycles = 0;
    bit          calm = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    logic [7:0]  img [0:REC_BYTES-1];

    function automatic logic [31:0] next_crc(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    task automatic clear_record();
        pos_q = '0;
        crc_q = ALL_ONES;
        shift_q = '0;
        stored_crc_q = '0;
        gen_q = '0;
        count_q = '0;
        used_q = '0;
        same_pair_q = '1;
        text_done_q = '0;
        head_err_q = '0;
        resv_err_q = 1'b0;
        rec_err_q = '0;
    endtask

    task automatic flag_entry(input logic [3:0] code);
        if (rec_err_q == ST_OK) rec_err_q = code;
    endtask

    task automatic flag_header(input logic [3:0] code);
        if (head_err_q == ST_OK) head_err_q = code;
    endtask

    task automatic text_char(input int idx, input int which, input int k, input int cap,
                             input int base, input logic [7:0] b, input logic [3:0] code,
                             input bit active);
        if (text_done_q[which]) return;
        for (int j = 0; j < idx; j++) begin
            if (text_store[j*TEXT_BYTES + base + k] != b) same_pair_q[j] = 1'b0;
        end
        text_store[idx*TEXT_BYTES + base + k] = b;
        if (b == 8'd0) begin
            if (k == 0 && active) flag_entry(code);
            text_done_q[which] = 1'b1;
        end else if (active && (b < MIN_PRINT || k == cap - 1)) begin
            flag_entry(code);
        end
    endtask

    task automatic slot_byte(input int idx, input int off, input logic [7:0] b);
        bit    active;
        logic [5:0] earlier;
        active = idx < count_q;
        if (off == 0) begin
            same_pair_q = '1;
            text_done_q = '0;
            if (active) begin
                if (b >= BIND_LIMIT) flag_entry(ST_INDEX);
                else if (used_q[b[2:0]]) flag_entry(ST_REUSED);
                else used_q[b[2:0]] = 1'b1;
            end
        end else if (off >= 4 && off < 132) begin
            text_char(idx, 0, off - 4, 128, 0, b, ST_DEVICE, active);
        end else if (off >= 132) begin
            text_char(idx, 1, off - 132, 64, 128, b, ST_CAPA, active);
            earlier = 6'((1 << idx) - 1);
            if (off == SLOT_BYTES - 1 && active && (same_pair_q & earlier) != 0)
                flag_entry(ST_DUP);
        end
    endtask

    task automatic absorb_byte(input int p, input logic [7:0] b);
        crc_q = next_crc(crc_q, (p >= 12 && p <= 15) ? 8'd0 : b);
        shift_q = {b, shift_q[31:8]};
        if (p == 3 && shift_q != REC_MAGIC) flag_header(ST_MAGIC);
        else if (p == 5 && shift_q[31:16] != schema_q) flag_header(ST_VERSION);
        else if (p == 7 && shift_q[31:16] != 16'(REC_BYTES)) flag_header(ST_SIZE);
        else if (p == 11) gen_q = shift_q;
        else if (p == 15) stored_crc_q = shift_q;
        else if (p == 48) begin
            count_q = b;
            if (gen_q == 0) flag_entry(ST_ZERO_GEN);
            else if (b > NUM_SLOTS) flag_entry(ST_COUNT);
        end else if (p >= 49 && p <= 51 && b != 0) resv_err_q = 1'b1;
        if (p >= 52 && p < 52 + NUM_SLOTS*SLOT_BYTES)
            slot_byte((p - 52) / SLOT_BYTES, (p - 52) % SLOT_BYTES, b);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int   p;
        t_out res;
        p = pos_q;
        if (p < REC_BYTES) absorb_byte(p, b);
        if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
        if (!last) return;
        if (p != REC_BYTES - 1) res.status = ST_LENGTH;
        else if (head_err_q != ST_OK) res.status = head_err_q;
        else if ((crc_q ^ ALL_ONES) != stored_crc_q) res.status = ST_CRC;
        else if (resv_err_q) res.status = ST_RESERVED;
        else res.status = rec_err_q;
        if (res.status >= ST_LENGTH && res.status <= ST_RESERVED) begin
            res.generation = '0;
            res.stored_count = '0;
        end else begin
            res.generation = gen_q;
            res.stored_count = count_q;
        end
        status_q.push_back(res);
        clear_record();
    endtask

    // prediction on every accepted byte, check on every accepted result
    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) predict_byte(i_data.data_byte, i_data.last_byte);
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                $error("unexpected result status=%0d", o_data.status);
                failures++;
            end else begin
                want = status_q.pop_front();
                if (o_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_data.status);
                    failures++;
                end
                if (o_data.generation !== want.generation) begin
                    $error("generation: expected %h, actual %h", want.generation,
                           o_data.generation);
                    failures++;
                end
                if (o_data.stored_count !== want.stored_count) begin
                    $error("stored_count: expected %0d, actual %0d", want.stored_count,
                           o_data.stored_count);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = 400;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 24) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_schema(input logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        schema_q = v;
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 255));
    endfunction

    task automatic set_text(input int s, input int which, input int len);
        int off;
        int cap;
        off = 52 + s*SLOT_BYTES + (which ? 132 : 4);
        cap = which ? 64 : 128;
        for (int k = 0; k < cap; k++)
            img[off + k] = (k < len) ? printable() : (k == len) ? 8'd0 : 8'($urandom);
    endtask

    function automatic int text_len(input int cap);
        case ($urandom_range(0, 9))
            0: return 1;
            1: return cap - 1;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // well formed image with distinct bindings and distinct text pairs
    task automatic build_record(input int n, input logic [31:0] gen);
        int perm [NUM_SLOTS];
        int r;
        int t;
        for (int i = 0; i < REC_BYTES; i++) img[i] = 8'($urandom);
        {img[3], img[2], img[1], img[0]} = REC_MAGIC;
        {img[5], img[4]} = schema_q;
        {img[7], img[6]} = 16'(REC_BYTES);
        {img[11], img[10], img[9], img[8]} = gen;
        img[48] = 8'(n);
        img[49] = 8'd0;
        img[50] = 8'd0;
        img[51] = 8'd0;
        for (int i = 0; i < NUM_SLOTS; i++) perm[i] = i;
        for (int i = NUM_SLOTS - 1; i > 0; i--) begin
            r = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[r];
            perm[r] = t;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            img[52 + s*SLOT_BYTES] = 8'(perm[s]);
            set_text(s, 0, text_len(128));
            set_text(s, 1, text_len(64));
            img[52 + s*SLOT_BYTES + 4] = 8'h41 + 8'(s);
        end
    endtask

    task automatic seal_crc();
        logic [31:0] c;
        c = ALL_ONES;
        for (int p = 0; p < REC_BYTES; p++)
            c = next_crc(c, (p >= 12 && p <= 15) ? 8'd0 : img[p]);
        {img[15], img[14], img[13], img[12]} = c ^ ALL_ONES;
    endtask

    task automatic stream_record(input int len);
        for (int p = 0; p < len; p++)
            send_byte(p < REC_BYTES ? img[p] : 8'($urandom), p == len - 1);
    endtask

    task automatic good_and_send(input int n, input logic [31:0] gen);
        build_record(n, gen);
        seal_crc();
        stream_record(REC_BYTES);
    endtask

    task automatic copy_pair(input int from, input int to);
        for (int k = 4; k < SLOT_BYTES; k++)
            img[52 + to*SLOT_BYTES + k] = img[52 + from*SLOT_BYTES + k];
    endtask

    task automatic test_good_records();
        good_and_send(NUM_SLOTS, 32'hffff_ffff);
        good_and_send(0, 32'd1);
        good_and_send(3, $urandom);
    endtask

    task automatic test_header_errors();
        build_record(2, 32'h1234_5678); img[2] = 8'h00; seal_crc(); stream_record(REC_BYTES);
        build_record(2, 32'h1); img[4] ^= 8'h01; seal_crc(); stream_record(REC_BYTES);
        build_record(2, 32'h2); img[7] = 8'hff; seal_crc(); stream_record(REC_BYTES);
        build_record(2, 32'h3); seal_crc(); img[12] ^= 8'h80; stream_record(REC_BYTES);
        build_record(2, 32'h4); img[50] = 8'h01; seal_crc(); stream_record(REC_BYTES);
        build_record(2, 32'h0); seal_crc(); stream_record(REC_BYTES);
        build_record(7, 32'h5); seal_crc(); stream_record(REC_BYTES);
        build_record(255, 32'h6); seal_crc(); stream_record(REC_BYTES);
    endtask

    task automatic test_entry_errors();
        build_record(3, 32'h7); img[52 + SLOT_BYTES] = 8'd6; seal_crc();
        stream_record(REC_BYTES);
        build_record(3, 32'h8); img[52 + 2*SLOT_BYTES] = img[52]; seal_crc();
        stream_record(REC_BYTES);
        build_record(3, 32'h9); img[52 + 4] = 8'd0; seal_crc(); stream_record(REC_BYTES);
        build_record(3, 32'ha); set_text(1, 0, 128); seal_crc(); stream_record(REC_BYTES);
        build_record(3, 32'hb); img[52 + 5] = 8'h1f; img[52 + 6] = 8'd0; seal_crc();
        stream_record(REC_BYTES);
        build_record(3, 32'hc); set_text(2, 1, 64); seal_crc(); stream_record(REC_BYTES);
        build_record(3, 32'hd); img[52 + SLOT_BYTES + 132] = 8'd0; seal_crc();
        stream_record(REC_BYTES);
        build_record(4, 32'he); copy_pair(0, 3); seal_crc(); stream_record(REC_BYTES);
        // a duplicate in an unchecked slot is passed over
        build_record(2, 32'hf); copy_pair(0, 4); img[52 + 5*SLOT_BYTES] = 8'd9; seal_crc();
        stream_record(REC_BYTES);
    endtask

    task automatic test_lengths();
        build_record(1, 32'h10); seal_crc();
        stream_record(1);
        stream_record(REC_BYTES - 1);
        stream_record(REC_BYTES + 1);
        stream_record(2100);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_schema_extremes();
        write_schema(16'h0000);
        good_and_send(1, 32'h20);
        write_schema(16'hffff);
        good_and_send(2, 32'h21);
        build_record(2, 32'h22); img[5] = 8'h7f; seal_crc(); stream_record(REC_BYTES);
        write_schema(16'h0001);
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 60; i++) send_byte(8'($urandom), 1'b1);
        good_and_send(2, 32'h30);
    endtask

    task automatic test_random();
        int kind;
        int len;
        for (int r = 0; r < 48; r++) begin
            if (r % 12 == 11) write_schema(16'($urandom));
            if (r == 42) calm = 1;
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1233, 2200)
                                                  : $urandom_range(1, 80);
                for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
            end else begin
                build_record($urandom_range(0, 6), ($urandom_range(0, 9) == 0) ? 0 : $urandom);
                case (kind)
                    3: img[52 + $urandom_range(0, 5)*SLOT_BYTES] = 8'($urandom_range(0, 255));
                    4: img[52 + $urandom_range(1, 5)*SLOT_BYTES] = img[52];
                    5: copy_pair($urandom_range(0, 2), $urandom_range(3, 5));
                    6: img[52 + $urandom_range(0, 5)*SLOT_BYTES + $urandom_range(4, 195)] =
                           8'($urandom_range(0, 31));
                    7: img[48] = 8'($urandom_range(7, 255));
                    8: img[$urandom_range(0, 51)] = 8'($urandom);
                    9: set_text($urandom_range(0, 5), $urandom_range(0, 1), 0);
                    default: ;
                endcase
                seal_crc();
                if (kind == 10) img[$urandom_range(0, REC_BYTES - 1)] ^= 8'h10;
                stream_record(REC_BYTES);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_data <= '0;
        schema_q = 16'd1;
        for (int i = 0; i < NUM_SLOTS*TEXT_BYTES; i++) text_store[i] = 8'd0;
        clear_record();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_records();
        test_header_errors();
        test_entry_errors();
        test_lengths();
        test_schema_extremes();
        test_backpressure();
        test_random();

        drain();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
